[rtl/core/gbv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbv_pkg
// Shared constants, codes and types of the growable bit vector store.
// ----------------------------------------------------------------------------
package gbv_pkg;

  localparam int WORD_BITS   = 16;
  localparam int WORD_IDX_W  = $clog2(WORD_BITS);
  localparam int MAX_BITS    = 4096;
  localparam int STORE_WORDS = MAX_BITS / WORD_BITS;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int IDX_W       = $clog2(MAX_BITS);
  localparam int CAP_W       = IDX_W + 1;
  localparam int WCNT_W      = ADDR_W + 1;
  localparam int CMD_W       = 4;
  localparam int OP_W        = 3;
  localparam int PCNT_W      = WORD_IDX_W + 1;

  localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET        = 4'd0,
    CMD_CLEAR      = 4'd1,
    CMD_INVERT     = 4'd2,
    CMD_TEST       = 4'd3,
    CMD_FILL       = 4'd4,
    CMD_INVERT_ALL = 4'd5,
    CMD_CAPACITY   = 4'd6,
    CMD_DEFAULT    = 4'd7,
    CMD_COUNT      = 4'd8,
    CMD_ANY        = 4'd9,
    CMD_COMBINE    = 4'd10
  } cmd_e;

  typedef enum logic [OP_W-1:0] {
    OP_OR   = 3'd0,
    OP_XOR  = 3'd1,
    OP_AND  = 3'd2,
    OP_ORN  = 3'd3,
    OP_ANDN = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_FILL,
    ST_SWEEP,
    ST_IMM
  } state_e;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_W-1:0]    raddr;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic             bit_value;
    logic [CAP_W-1:0] set_count;
    logic [CAP_W-1:0] capacity_now;
    logic             status;
  } res_t;

  // Population count of one word as four nibble counts and a short sum.
  function automatic logic [PCNT_W-1:0] popcnt_word(input logic [WORD_BITS-1:0] w);
    logic [2:0] nib [4];
    logic [PCNT_W-1:0] sum;
    for (int n = 0; n < 4; n++) begin
      nib[n] = 3'(w[4*n]) + 3'(w[4*n+1]) + 3'(w[4*n+2]) + 3'(w[4*n+3]);
    end
    sum = PCNT_W'(nib[0]) + PCNT_W'(nib[1]) + PCNT_W'(nib[2]) + PCNT_W'(nib[3]);
    return sum;
  endfunction

endpackage

[rtl/core/gbv_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbv_in_if / gbv_out_if
// Valid/ready channels carrying commands into and results out of the store.
// ----------------------------------------------------------------------------
interface gbv_in_if import gbv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [IDX_W-1:0]  bit_index;
  logic [CAP_W-1:0]  capacity_value;
  logic              fill_value;
  logic [ADDR_W-1:0] word_index;
  logic [WORD_BITS-1:0] src_word;
  logic [OP_W-1:0]   logic_op;

  modport source(output valid, cmd, bit_index, capacity_value, fill_value, word_index,
                 src_word, logic_op, input ready);
  modport sink(input valid, cmd, bit_index, capacity_value, fill_value, word_index,
               src_word, logic_op, output ready);
endinterface

interface gbv_out_if import gbv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             bit_value;
  logic [CAP_W-1:0] set_count;
  logic [CAP_W-1:0] capacity_now;
  logic             status;

  modport source(output valid, bit_value, set_count, capacity_now, status, input ready);
  modport sink(input valid, bit_value, set_count, capacity_now, status, output ready);
endinterface

[rtl/core/gbv_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbv_mem
// Word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbv_mem import gbv_pkg::*; (
  input  logic                 clk_i,
  input  mem_req_t             req_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] store_q [STORE_WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      store_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Hold read data while no read is issued.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= store_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/gbv_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbv_ctrl
// Command sequencer: decode, read-modify-write, fill and sweep walks.
// ----------------------------------------------------------------------------
module gbv_ctrl import gbv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  gbv_in_if.sink               in_i,
  input  logic [WORD_BITS-1:0] rdata_i,
  output mem_req_t             mem_o,
  input  logic                 res_rdy_i,
  output res_t                 res_o
);

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [IDX_W-1:0]     bidx_q, bidx_d;
  logic                 fill_q, fill_d;
  op_e                  op_q, op_d;
  logic [WORD_BITS-1:0] src_q, src_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [ADDR_W-1:0]    ptr_q, ptr_d;
  logic [ADDR_W-1:0]    end_q, end_d;
  logic [WORD_BITS-1:0] fword_q, fword_d;
  logic                 lmod_q, lmod_d;
  logic [WORD_BITS-1:0] tmask_q, tmask_d;
  logic [CAP_W-1:0]     cnt_q, cnt_d;
  logic [CAP_W-1:0]     valid_q, valid_d;
  logic                 dflt_q, dflt_d;
  logic [CAP_W-1:0]     nvalid_q, nvalid_d;
  logic                 ndflt_q, ndflt_d;
  logic                 ibit_q, ibit_d;
  logic                 ista_q, ista_d;

  logic [CAP_W-1:0]     vup, cup, bp1;
  logic [WCNT_W-1:0]    words, to_words;
  logic [WORD_BITS-1:0] bmask, rmw_word, fill_last, masked;
  logic [CAP_W-1:0]     sum;
  cmd_e                 in_cmd;

  assign in_cmd   = cmd_e'(in_i.cmd);
  assign vup      = valid_q + CAP_W'(WORD_BITS - 1);
  assign words    = vup[CAP_W-1:WORD_IDX_W];
  assign cup      = in_i.capacity_value + CAP_W'(WORD_BITS - 1);
  assign to_words = cup[CAP_W-1:WORD_IDX_W];
  assign bp1      = {1'b0, in_i.bit_index} + CAP_W'(1);
  assign bmask    = WORD_BITS'(1) << bidx_q[WORD_IDX_W-1:0];
  assign masked   = (ptr_q == end_q) ? (rdata_i & tmask_q) : rdata_i;
  assign sum      = cnt_q + CAP_W'(popcnt_word(masked));

  always_comb begin
    fill_last = fword_q;
    if (lmod_q) begin
      fill_last = (cmd_q == CMD_SET) ? (fword_q | bmask) : (fword_q & ~bmask);
    end
  end

  always_comb begin
    rmw_word = rdata_i;
    case (cmd_q)
      CMD_SET:    rmw_word = rdata_i | bmask;
      CMD_CLEAR:  rmw_word = rdata_i & ~bmask;
      CMD_INVERT: rmw_word = rdata_i ^ bmask;
      CMD_DEFAULT: begin
        if (fill_q) begin
          rmw_word = rdata_i | (WORD_ONES << valid_q[WORD_IDX_W-1:0]);
        end else begin
          rmw_word = rdata_i & ~(WORD_ONES << valid_q[WORD_IDX_W-1:0]);
        end
      end
      CMD_COMBINE: begin
        case (op_q)
          OP_OR:   rmw_word = rdata_i | src_q;
          OP_XOR:  rmw_word = rdata_i ^ src_q;
          OP_AND:  rmw_word = rdata_i & src_q;
          OP_ORN:  rmw_word = rdata_i | ~src_q;
          default: rmw_word = rdata_i & ~src_q;
        endcase
      end
      default: rmw_word = rdata_i;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    bidx_d   = bidx_q;
    fill_d   = fill_q;
    op_d     = op_q;
    src_d    = src_q;
    addr_d   = addr_q;
    ptr_d    = ptr_q;
    end_d    = end_q;
    fword_d  = fword_q;
    lmod_d   = lmod_q;
    tmask_d  = tmask_q;
    cnt_d    = cnt_q;
    valid_d  = valid_q;
    dflt_d   = dflt_q;
    nvalid_d = nvalid_q;
    ndflt_d  = ndflt_q;
    ibit_d   = ibit_q;
    ista_d   = ista_q;
    in_i.ready = 1'b0;
    mem_o    = '0;
    res_o    = '0;
    res_o.capacity_now = nvalid_q;

    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          cmd_d    = in_cmd;
          bidx_d   = in_i.bit_index;
          fill_d   = in_i.fill_value;
          op_d     = op_e'(in_i.logic_op);
          src_d    = in_i.src_word;
          nvalid_d = valid_q;
          ndflt_d  = dflt_q;
          ibit_d   = 1'b0;
          ista_d   = 1'b0;
          cnt_d    = '0;
          lmod_d   = 1'b0;
          ptr_d    = '0;
          addr_d   = in_i.bit_index[IDX_W-1:WORD_IDX_W];
          fword_d  = {WORD_BITS{dflt_q}};
          tmask_d  = (valid_q[WORD_IDX_W-1:0] == '0) ? WORD_ONES
                   : ~(WORD_ONES << valid_q[WORD_IDX_W-1:0]);
          mem_o.raddr = in_i.bit_index[IDX_W-1:WORD_IDX_W];
          state_d  = ST_IMM;
          unique case (in_cmd)
            CMD_SET, CMD_CLEAR: begin
              if (bp1 > valid_q) begin
                nvalid_d = bp1;
              end
              if ({1'b0, in_i.bit_index[IDX_W-1:WORD_IDX_W]} >= words) begin
                // Target word lies past the stored words: fill up to it.
                ptr_d   = words[ADDR_W-1:0];
                end_d   = in_i.bit_index[IDX_W-1:WORD_IDX_W];
                lmod_d  = 1'b1;
                state_d = ST_FILL;
              end else begin
                mem_o.re = 1'b1;
                state_d  = ST_RMW;
              end
            end
            CMD_INVERT, CMD_TEST: begin
              if ({1'b0, in_i.bit_index} >= valid_q) begin
                ista_d = (in_cmd == CMD_INVERT);
                ibit_d = (in_cmd == CMD_TEST) & dflt_q;
              end else begin
                mem_o.re = 1'b1;
                state_d  = ST_RMW;
              end
            end
            CMD_FILL: begin
              fword_d = {WORD_BITS{in_i.fill_value}};
              ndflt_d = in_i.fill_value;
              if (words != '0) begin
                end_d   = ADDR_W'(words - WCNT_W'(1));
                state_d = ST_FILL;
              end
            end
            CMD_INVERT_ALL, CMD_COUNT, CMD_ANY: begin
              if (in_cmd == CMD_INVERT_ALL) begin
                ndflt_d = ~dflt_q;
              end
              if (in_cmd == CMD_ANY) begin
                ibit_d = dflt_q;
              end
              if (words != '0) begin
                end_d       = ADDR_W'(words - WCNT_W'(1));
                mem_o.re    = 1'b1;
                mem_o.raddr = '0;
                state_d     = ST_SWEEP;
              end
            end
            CMD_CAPACITY: begin
              if (in_i.capacity_value > CAP_W'(MAX_BITS)) begin
                ista_d = 1'b1;
              end else begin
                nvalid_d = in_i.capacity_value;
                if (in_i.capacity_value > valid_q && to_words > words) begin
                  ptr_d   = words[ADDR_W-1:0];
                  end_d   = ADDR_W'(to_words - WCNT_W'(1));
                  state_d = ST_FILL;
                end
              end
            end
            CMD_DEFAULT: begin
              ndflt_d = in_i.fill_value;
              if (in_i.fill_value != dflt_q && valid_q[WORD_IDX_W-1:0] != '0) begin
                // Retouch the bits above the capacity in the partial last word.
                addr_d      = valid_q[IDX_W-1:WORD_IDX_W];
                mem_o.re    = 1'b1;
                mem_o.raddr = valid_q[IDX_W-1:WORD_IDX_W];
                state_d     = ST_RMW;
              end
            end
            CMD_COMBINE: begin
              if ({1'b0, in_i.word_index} >= words || in_i.logic_op > OP_W'(OP_ANDN)) begin
                ista_d = 1'b1;
              end else begin
                addr_d      = in_i.word_index;
                mem_o.re    = 1'b1;
                mem_o.raddr = in_i.word_index;
                state_d     = ST_RMW;
              end
            end
            default: ista_d = 1'b1;
          endcase
        end
      end

      ST_RMW: begin
        if (res_rdy_i) begin
          mem_o.we        = (cmd_q != CMD_TEST);
          mem_o.waddr     = addr_q;
          mem_o.wdata     = rmw_word;
          res_o.valid     = 1'b1;
          res_o.bit_value = (cmd_q == CMD_TEST) & rdata_i[bidx_q[WORD_IDX_W-1:0]];
          valid_d = nvalid_q;
          dflt_d  = ndflt_q;
          state_d = ST_IDLE;
        end
      end

      ST_FILL: begin
        mem_o.waddr = ptr_q;
        if (ptr_q != end_q) begin
          mem_o.we    = 1'b1;
          mem_o.wdata = fword_q;
          ptr_d       = ptr_q + ADDR_W'(1);
        end else if (res_rdy_i) begin
          mem_o.we    = 1'b1;
          mem_o.wdata = fill_last;
          res_o.valid = 1'b1;
          valid_d = nvalid_q;
          dflt_d  = ndflt_q;
          state_d = ST_IDLE;
        end
      end

      ST_SWEEP: begin
        mem_o.waddr = ptr_q;
        mem_o.wdata = ~rdata_i;
        if (ptr_q != end_q) begin
          mem_o.we    = (cmd_q == CMD_INVERT_ALL);
          mem_o.re    = 1'b1;
          mem_o.raddr = ptr_q + ADDR_W'(1);
          cnt_d       = sum;
          ptr_d       = ptr_q + ADDR_W'(1);
        end else if (res_rdy_i) begin
          mem_o.we        = (cmd_q == CMD_INVERT_ALL);
          res_o.valid     = 1'b1;
          res_o.set_count = (cmd_q == CMD_COUNT) ? sum : '0;
          res_o.bit_value = (cmd_q == CMD_ANY) & (sum != '0);
          valid_d = nvalid_q;
          dflt_d  = ndflt_q;
          state_d = ST_IDLE;
        end
      end

      ST_IMM: begin
        if (res_rdy_i) begin
          res_o.valid     = 1'b1;
          res_o.bit_value = ibit_q;
          res_o.status    = ista_q;
          valid_d = nvalid_q;
          dflt_d  = ndflt_q;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      dflt_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      dflt_q  <= dflt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    bidx_q   <= bidx_d;
    fill_q   <= fill_d;
    op_q     <= op_d;
    src_q    <= src_d;
    addr_q   <= addr_d;
    ptr_q    <= ptr_d;
    end_q    <= end_d;
    fword_q  <= fword_d;
    lmod_q   <= lmod_d;
    tmask_q  <= tmask_d;
    cnt_q    <= cnt_d;
    nvalid_q <= nvalid_d;
    ndflt_q  <= ndflt_d;
    ibit_q   <= ibit_d;
    ista_q   <= ista_d;
  end

endmodule

[rtl/core/growable_bit_vector_store_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// growable_bit_vector_store_unit
// Bit vector of up to 4096 bits in 16-bit words, with capacity and default.
// ----------------------------------------------------------------------------
//  Channel | Dir | Transaction
//  --------+-----+------------------------------------------------------------
//  in_i    | in  | one command: cmd, bit_index, capacity_value, fill_value,
//          |     | word_index, src_word, logic_op
//  out_o   | out | one result per command: bit_value, set_count,
//          |     | capacity_now, status
//
//  One command is in work at a time; a command is taken only while the
//  sequencer is idle. Test, set, clear, invert, combine and set default
//  read one word and write it back, test without the write; all immediate
//  answers need no word access. Fill all, invert all, count and any set
//  walk every stored word, one word a cycle through the single store port
//  pair, and answer at once with an empty vector. Growth fills each new
//  word at one a cycle.
//  Reset clears capacity and default; the word store is not cleared, since
//  only words already written below the capacity are ever read.
//  A result waits in the output register; the next command is accepted
//  meanwhile and stalls only at its last step until the register frees up.
// ----------------------------------------------------------------------------
module growable_bit_vector_store_unit import gbv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbv_in_if.sink     in_i,
  gbv_out_if.source  out_o
);

  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] mem_rdata;
  res_t                 res;
  logic                 res_rdy;

  logic                 out_valid_q;
  logic                 out_bit_q;
  logic [CAP_W-1:0]     out_count_q;
  logic [CAP_W-1:0]     out_cap_q;
  logic                 out_status_q;

  // Sequencer: decodes the command and drives the store.
  gbv_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .rdata_i   (mem_rdata),
    .mem_o     (mem_req),
    .res_rdy_i (res_rdy),
    .res_o     (res)
  );

  // Word store with registered read data.
  gbv_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // The slot is free when empty or when its transaction leaves this cycle.
  assign res_rdy = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the payload with each new result; hold it while stalled.
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_bit_q    <= res.bit_value;
      out_count_q  <= res.set_count;
      out_cap_q    <= res.capacity_now;
      out_status_q <= res.status;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.bit_value    = out_bit_q;
  assign out_o.set_count    = out_count_q;
  assign out_o.capacity_now = out_cap_q;
  assign out_o.status       = out_status_q;

`ifndef SYNTH
  // A finished result never overwrites one still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (!out_valid_q || out_o.ready))
    else $error("result pushed into a full output register");

  // Reported capacity stays within the store.
  a_cap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cap_q <= CAP_W'(MAX_BITS)))
    else $error("capacity beyond store size");

  // An accepted command keeps the sequencer busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second command accepted back to back");

  // No write and read of the same word land on the same edge.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("store read and write collide");
`endif

endmodule
